[hdl/vqdm_pkg.sv]
// Package: shared types and constants for the virtqueue descriptor manager.
`default_nettype none
package vqdm_pkg;
   localparam logic [2:0] ST_TAKEN   = 3'd0;
   localparam logic [2:0] ST_POSTED  = 3'd1;
   localparam logic [2:0] ST_NO_ROOM = 3'd2;
   localparam logic [2:0] ST_RETIRED = 3'd3;
   localparam logic [2:0] ST_NOTHING = 3'd4;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_RETIRE = 1'b1;

   localparam logic REG_QUEUE_SIZE   = 1'b0;
   localparam logic REG_QUEUE_NUMBER = 1'b1;

   localparam int FLAG_NEXT  = 0;
   localparam int FLAG_WRITE = 1;

   typedef struct packed {
      logic        cmd;
      logic [63:0] buf_addr;
      logic [31:0] buf_len;
      logic [8:0]  chain_count;
      logic [31:0] token;
      logic [15:0] device_used_idx;
      logic [7:0]  used_id;
      logic [31:0] used_len;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  chain_head;
      logic [15:0] avail_index;
      logic        notify;
      logic [15:0] notify_queue;
      logic [31:0] token_out;
      logic [31:0] used_length_out;
      logic [8:0]  free_count_out;
   } rsp_type;

   typedef struct packed {
      logic [0:0]  index;
      logic [15:0] data;
   } csr_type;
endpackage
`default_nettype wire

[hdl/vqdm_if.sv]
// Interface: valid/ready channel carrying a payload.
`default_nettype none
interface vqdm_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/virtqueue_descriptor_manager_core.sv]
// Top level: driver side of one split virtqueue.
// Add item: result after the decode and add states (link read, table write).
// Retire item: bit-serial remainder of used id by queue size, then a chain walk
//   through the link table that returns the chain to the free list. Nothing used: ST_NOTHING.
// The next item can be accepted from the cycle after the result is taken.
// Reset (sync, active high) or queue-size write: clearing pass over the queue-size entries.
`default_nettype none
module virtqueue_descriptor_manager_core #(
   parameter int MAX_DESCRIPTORS = 256
) (
   input wire logic clock,
   input wire logic reset,
   vqdm_if.sink    req,
   vqdm_if.source  rsp,
   vqdm_if.sink    csr
);
   import vqdm_pkg::*;

   localparam int CAP = (MAX_DESCRIPTORS < 256) ? MAX_DESCRIPTORS : 256;
   localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_ADD    = 4'd3;
   localparam logic [3:0] S_OUT    = 4'd4;
   localparam logic [3:0] S_MOD    = 4'd5;
   localparam logic [3:0] S_READ   = 4'd6;
   localparam logic [3:0] S_RTK    = 4'd7;
   localparam logic [3:0] S_WALK   = 4'd8;
   localparam logic [3:0] S_WAIT   = 4'd9;
   localparam logic [3:0] S_LINK   = 4'd10;

   // Descriptor storage: address/length are write-only, flags and links are walked.
   logic [63:0]   desc_address [CAP];
   logic [31:0]   desc_length  [CAP];
   logic [1:0]    desc_flags   [CAP];
   logic [AW-1:0] desc_link    [CAP];
   logic [31:0]   head_token   [CAP];
   logic [7:0]    avail_ring   [CAP];

   logic [3:0]    state_ff, state_in;
   logic [8:0]    qsize_ff;
   logic [15:0]   qnum_ff;
   logic [AW-1:0] clr_ff;
   logic [15:0]   avail_idx_ff, last_used_ff;
   logic [AW-1:0] avail_slot_ff;
   logic [8:0]    free_count_ff, progress_ff, chain_len_ff, added_ff;
   logic [AW-1:0] free_head_ff, chain_first_ff, cursor_ff, idx_ff, head_ff;
   logic          refused_ff;
   logic [7:0]    rem_ff;
   logic [2:0]    bit_ff;
   logic [31:0]   tok_ff;
   req_type       item_ff;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_load;
   logic [AW-1:0] link_rd_ff;
   logic [1:0]    flag_rd_ff;
   logic [31:0]   tok_rd_ff;

   logic          size_write, item_take;
   logic [8:0]    csr_clamp;
   logic          first_elem, refuse, is_last, walk_more, clear_done;
   logic [8:0]    n_eff, chain_total, prog_next, fc_sum;
   logic [9:0]    fc_wide;
   logic [8:0]    rem_shift, rem_next;
   logic [AW-1:0] cur_eff, head_eff, clr_link, slot_next;
   logic [1:0]    flags_in;

   assign size_write  = csr.valid && csr.ready && (csr.payload.index == REG_QUEUE_SIZE);
   assign item_take   = req.valid && req.ready;
   assign req.ready   = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready   = 1'b1;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;
   assign rsp_load    = (state_ff == S_ADD) || (state_ff == S_LINK) || (state_ff == S_OUT);

   // Queue size clamps to 1..CAP.
   always_comb begin
      csr_clamp = csr.payload.data[8:0];
      if (csr_clamp == 9'd0) begin
         csr_clamp = 9'd1;
      end else if (csr_clamp > 9'(CAP)) begin
         csr_clamp = 9'(CAP);
      end
   end

   always_comb begin
      // Chain bookkeeping: the first element fixes length, head and refusal.
      first_elem  = (progress_ff == 9'd0);
      n_eff       = (item_ff.chain_count == 9'd0) ? 9'd1 : item_ff.chain_count;
      chain_total = first_elem ? n_eff : chain_len_ff;
      prog_next   = progress_ff + 9'd1;
      is_last     = prog_next >= chain_total;
      refuse      = first_elem ? (n_eff > free_count_ff) : refused_ff;
      cur_eff     = first_elem ? free_head_ff : cursor_ff;
      head_eff    = first_elem ? free_head_ff : chain_first_ff;
      flags_in    = 2'b00;
      flags_in[FLAG_WRITE] = item_ff.buf_addr[0];
      flags_in[FLAG_NEXT]  = !is_last;
      // Returned descriptors, free count saturates at the queue size.
      fc_wide = {1'b0, free_count_ff} + {1'b0, added_ff};
      fc_sum  = (fc_wide > {1'b0, qsize_ff}) ? qsize_ff : fc_wide[8:0];
      // Shared compare/subtract: one restoring step of used id mod queue size.
      rem_shift = {rem_ff, item_ff.used_id[bit_ff]};
      rem_next  = (rem_shift >= qsize_ff) ? rem_shift - qsize_ff : rem_shift;
      walk_more = flag_rd_ff[FLAG_NEXT] && (added_ff < qsize_ff);
      // Wrapping counters at the queue size.
      slot_next  = (9'(avail_slot_ff) + 9'd1 == qsize_ff) ? '0 : avail_slot_ff + AW'(1);
      clr_link   = (9'(clr_ff) + 9'd1 == qsize_ff) ? '0 : clr_ff + AW'(1);
      clear_done = (9'(clr_ff) == qsize_ff - 9'd1);
   end

   // Result item for the state that produces it.
   always_comb begin
      rsp_in = '0;
      rsp_in.avail_index = avail_idx_ff;
      rsp_in.free_count_out = free_count_ff;
      case (state_ff)
         S_ADD: begin
            if (refuse) begin
               rsp_in.status = ST_NO_ROOM;
            end else begin
               rsp_in.chain_head = 8'(head_eff);
               if (is_last) begin
                  rsp_in.status = ST_POSTED;
                  rsp_in.notify = 1'b1;
                  rsp_in.notify_queue = qnum_ff;
                  rsp_in.avail_index = avail_idx_ff + 16'd1;
                  rsp_in.free_count_out = free_count_ff - chain_total;
               end else begin
                  rsp_in.status = ST_TAKEN;
               end
            end
         end
         S_LINK: begin
            rsp_in.status = ST_RETIRED;
            rsp_in.chain_head = 8'(head_ff);
            rsp_in.token_out = tok_ff;
            rsp_in.used_length_out = item_ff.used_len;
            rsp_in.free_count_out = fc_sum;
         end
         default: begin
            rsp_in.status = ST_NOTHING;
         end
      endcase
   end

   // RAM ports: registered reads at idx_ff, at most one write per array per cycle.
   always_ff @(posedge clock) begin
      link_rd_ff <= desc_link[idx_ff];
      flag_rd_ff <= desc_flags[idx_ff];
      tok_rd_ff  <= head_token[idx_ff];
      if (state_ff == S_CLEAR) begin
         desc_flags[clr_ff] <= 2'b00;
         head_token[clr_ff] <= 32'd0;
         desc_link[clr_ff]  <= clr_link;
      end else if (state_ff == S_ADD && !refuse) begin
         desc_address[cur_eff] <= {item_ff.buf_addr[63:1], 1'b0};
         desc_length[cur_eff]  <= item_ff.buf_len;
         desc_flags[cur_eff]   <= flags_in;
         if (first_elem) begin
            head_token[cur_eff] <= item_ff.token;
         end
         if (is_last) begin
            avail_ring[avail_slot_ff] <= 8'(head_eff);
         end
      end else if (state_ff == S_RTK) begin
         head_token[idx_ff] <= 32'd0;
      end else if (state_ff == S_LINK) begin
         desc_link[idx_ff] <= free_head_ff;
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         qsize_ff <= 9'(CAP);
         qnum_ff <= 16'd0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         avail_idx_ff <= 16'd0;
         avail_slot_ff <= '0;
         last_used_ff <= 16'd0;
         free_count_ff <= 9'(CAP);
         free_head_ff <= '0;
         progress_ff <= 9'd0;
         refused_ff <= 1'b0;
         chain_len_ff <= 9'd0;
         chain_first_ff <= '0;
         cursor_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready && csr.payload.index == REG_QUEUE_NUMBER) begin
            qnum_ff <= csr.payload.data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff <= rsp_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (size_write) begin
            qsize_ff <= csr_clamp;
            clr_ff <= '0;
            avail_idx_ff <= 16'd0;
            avail_slot_ff <= '0;
            last_used_ff <= 16'd0;
            free_count_ff <= csr_clamp;
            free_head_ff <= '0;
            progress_ff <= 9'd0;
            refused_ff <= 1'b0;
            chain_len_ff <= 9'd0;
            chain_first_ff <= '0;
            cursor_ff <= '0;
         end else begin
            case (state_ff)
               S_CLEAR: begin
                  clr_ff <= clr_ff + AW'(1);
               end
               S_IDLE: begin
                  // Point the link read at the write cursor right away.
                  if (item_take) begin
                     item_ff <= req.payload;
                     idx_ff <= cur_eff;
                  end
               end
               S_DECODE: begin
                  rem_ff <= 8'd0;
                  bit_ff <= 3'd7;
               end
               S_MOD: begin
                  rem_ff <= rem_next[7:0];
                  bit_ff <= bit_ff - 3'd1;
                  if (bit_ff == 3'd0) begin
                     idx_ff <= rem_next[AW-1:0];
                  end
               end
               S_RTK: begin
                  head_ff <= idx_ff;
                  tok_ff <= tok_rd_ff;
                  added_ff <= 9'd1;
               end
               S_WALK: begin
                  if (walk_more) begin
                     idx_ff <= link_rd_ff;
                     added_ff <= added_ff + 9'd1;
                  end
               end
               S_LINK: begin
                  free_count_ff <= fc_sum;
                  free_head_ff <= head_ff;
                  last_used_ff <= last_used_ff + 16'd1;
               end
               S_ADD: begin
                  if (first_elem) begin
                     chain_len_ff <= n_eff;
                     chain_first_ff <= free_head_ff;
                  end
                  if (!refuse && !is_last) begin
                     cursor_ff <= link_rd_ff;
                  end
                  if (!refuse && is_last) begin
                     free_head_ff <= link_rd_ff;
                     free_count_ff <= free_count_ff - chain_total;
                     avail_idx_ff <= avail_idx_ff + 16'd1;
                     avail_slot_ff <= slot_next;
                  end
                  if (is_last) begin
                     progress_ff <= 9'd0;
                     refused_ff <= 1'b0;
                  end else begin
                     progress_ff <= prog_next;
                     refused_ff <= refuse;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      if (size_write) begin
         state_in = S_CLEAR;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (clear_done) begin
                  state_in = S_IDLE;
               end
            end
            S_IDLE: begin
               if (item_take) begin
                  state_in = S_DECODE;
               end
            end
            S_DECODE: begin
               if (item_ff.cmd == CMD_ADD) begin
                  state_in = S_ADD;
               end else if (progress_ff != 9'd0 ||
                            last_used_ff == item_ff.device_used_idx) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_MOD;
               end
            end
            S_MOD: begin
               if (bit_ff == 3'd0) begin
                  state_in = S_READ;
               end
            end
            S_READ: state_in = S_RTK;
            S_RTK: state_in = S_WALK;
            // Each further link goes through the wait state for the registered read.
            S_WALK: state_in = walk_more ? S_WAIT : S_LINK;
            S_WAIT: state_in = S_WALK;
            S_LINK: state_in = S_IDLE;
            S_ADD: state_in = S_IDLE;
            S_OUT: state_in = S_IDLE;
            default: state_in = S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
